/* rtl/core/hcd_pkg.sv */
// Shared types and constants for the HTTP chunked body decoder.
package hcd_pkg;

  localparam int SIZE_BITS  = 32;
  localparam int LINE_LIMIT = 32;
  localparam int LINE_W     = $clog2(LINE_LIMIT + 1);

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UF    = 8'h46;
  localparam logic [7:0] CH_UX    = 8'h58;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LF_HEX = 8'h66;
  localparam logic [7:0] CH_LX    = 8'h78;

  // One body byte as held in the input register.
  typedef struct packed {
    logic [7:0] byte_val;
    logic       last;
  } in_item_t;

  // What processing one byte yields toward the result register.
  typedef struct packed {
    logic       emit;
    logic [7:0] data;
    logic       is_end;
    logic       ok;
  } step_res_t;

endpackage

/* rtl/core/hcd_in_reg.sv */
// Input register stage of the chunked body decoder.
module hcd_in_reg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  hcd_pkg::in_item_t in_item,
  input  logic              take,
  output logic              hold_valid,
  output hcd_pkg::in_item_t hold_item
);

  logic              valid_r;
  logic              valid_nxt;
  hcd_pkg::in_item_t item_r;
  logic              load;

  // The register frees up in the same cycle its item moves on.
  assign in_tready = !valid_r || take;
  assign load      = in_tvalid && in_tready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_r <= in_item;
    end
  end

  assign hold_valid = valid_r;
  assign hold_item  = item_r;

endmodule

/* rtl/core/hcd_parse.sv */
// Framing state and per-byte next-state logic of the chunked body decoder.
module hcd_parse (
  input  logic               clk,
  input  logic               rst_n,
  input  hcd_pkg::in_item_t  item,
  input  logic               step_en,
  output hcd_pkg::step_res_t res
);

  typedef enum logic [4:0] {
    PH_LINE = 5'b00001,
    PH_DATA = 5'b00010,
    PH_CR   = 5'b00100,
    PH_LF   = 5'b01000,
    PH_DONE = 5'b10000
  } phase_t;

  typedef enum logic [7:0] {
    NP_LEAD = 8'b00000001,
    NP_SIGN = 8'b00000010,
    NP_ZERO = 8'b00000100,
    NP_HEX  = 8'b00001000,
    NP_DIG  = 8'b00010000,
    NP_END  = 8'b00100000,
    NP_NONE = 8'b01000000,
    NP_OVER = 8'b10000000
  } num_phase_t;

  phase_t                          phase_r, phase_nxt;
  num_phase_t                      nphase_r, nphase_nxt;
  logic [hcd_pkg::SIZE_BITS-1:0]   remain_r, remain_nxt;
  logic [hcd_pkg::SIZE_BITS-1:0]   accum_r, accum_nxt;
  logic [hcd_pkg::LINE_W-1:0]      len_r, len_nxt;
  logic                            prev_cr_r, prev_cr_nxt;
  logic                            neg_r, neg_nxt;
  logic                            err_r, err_nxt;

  logic [7:0]                      c;
  logic                            is_dig, is_lhex, is_uhex, is_hex, is_space;
  logic [3:0]                      dval;
  logic                            acc_full;
  logic [hcd_pkg::LINE_W:0]        len_inc;
  logic                            digit_start;
  logic                            ok;

  assign c        = item.byte_val;
  assign is_dig   = (c >= hcd_pkg::CH_ZERO) && (c <= hcd_pkg::CH_NINE);
  assign is_lhex  = (c >= hcd_pkg::CH_LA) && (c <= hcd_pkg::CH_LF_HEX);
  assign is_uhex  = (c >= hcd_pkg::CH_UA) && (c <= hcd_pkg::CH_UF);
  assign is_hex   = is_dig || is_lhex || is_uhex;
  assign is_space = (c == hcd_pkg::CH_SPACE) || ((c >= hcd_pkg::CH_TAB) && (c <= hcd_pkg::CH_CR));
  // Digit value: letters fold onto 10..15 through their low three bits.
  assign dval     = is_dig ? c[3:0] : (4'd9 + {1'b0, c[2:0]});
  // Another digit would push the size past the configured width.
  assign acc_full = |accum_r[hcd_pkg::SIZE_BITS-1 -: 4];
  assign len_inc  = {1'b0, len_r} + {{hcd_pkg::LINE_W{1'b0}}, 1'b1};

  always_comb begin
    phase_nxt   = phase_r;
    nphase_nxt  = nphase_r;
    remain_nxt  = remain_r;
    accum_nxt   = accum_r;
    len_nxt     = len_r;
    prev_cr_nxt = prev_cr_r;
    neg_nxt     = neg_r;
    err_nxt     = err_r;
    digit_start = 1'b0;
    res.emit    = 1'b0;
    res.data    = c;
    res.is_end  = 1'b0;
    res.ok      = 1'b0;

    if (!err_r) begin
      case (phase_r)
        PH_LINE: begin
          if (c == hcd_pkg::CH_NUL) begin
            err_nxt = 1'b1;
          end else if ((c == hcd_pkg::CH_LF) && prev_cr_r) begin
            // End of the size line.
            if ((nphase_r == NP_LEAD) || (nphase_r == NP_SIGN) ||
                (nphase_r == NP_NONE) || (nphase_r == NP_OVER)) begin
              err_nxt = 1'b1;
            end else if (accum_r == '0) begin
              phase_nxt = PH_DONE;
            end else if (neg_r) begin
              err_nxt = 1'b1;
            end else begin
              remain_nxt = accum_r;
              phase_nxt  = PH_DATA;
            end
          end else if (len_inc > (hcd_pkg::LINE_W+1)'(hcd_pkg::LINE_LIMIT)) begin
            err_nxt = 1'b1;
          end else begin
            len_nxt     = len_inc[hcd_pkg::LINE_W-1:0];
            prev_cr_nxt = (c == hcd_pkg::CH_CR);
            case (nphase_r)
              NP_LEAD: begin
                if (is_space) begin
                  nphase_nxt = NP_LEAD;
                end else if (c == hcd_pkg::CH_PLUS) begin
                  nphase_nxt = NP_SIGN;
                end else if (c == hcd_pkg::CH_MINUS) begin
                  neg_nxt    = 1'b1;
                  nphase_nxt = NP_SIGN;
                end else begin
                  digit_start = 1'b1;
                end
              end
              NP_SIGN: begin
                digit_start = 1'b1;
              end
              NP_ZERO: begin
                if ((c == hcd_pkg::CH_LX) || (c == hcd_pkg::CH_UX)) begin
                  nphase_nxt = NP_HEX;
                end else if (is_hex) begin
                  nphase_nxt = acc_full ? NP_OVER : NP_DIG;
                  if (!acc_full) accum_nxt = {accum_r[hcd_pkg::SIZE_BITS-5:0], dval};
                end else begin
                  nphase_nxt = NP_END;
                end
              end
              NP_HEX, NP_DIG: begin
                if (is_hex) begin
                  nphase_nxt = acc_full ? NP_OVER : NP_DIG;
                  if (!acc_full) accum_nxt = {accum_r[hcd_pkg::SIZE_BITS-5:0], dval};
                end else begin
                  nphase_nxt = NP_END;
                end
              end
              default: begin
                nphase_nxt = nphase_r;
              end
            endcase
            // First character that may open the digits.
            if (digit_start) begin
              if (c == hcd_pkg::CH_ZERO) begin
                nphase_nxt = NP_ZERO;
              end else if (is_hex) begin
                nphase_nxt = acc_full ? NP_OVER : NP_DIG;
                if (!acc_full) accum_nxt = {accum_r[hcd_pkg::SIZE_BITS-5:0], dval};
              end else begin
                nphase_nxt = NP_NONE;
              end
            end
          end
        end
        PH_DATA: begin
          res.emit   = 1'b1;
          remain_nxt = remain_r - {{(hcd_pkg::SIZE_BITS-1){1'b0}}, 1'b1};
          if (remain_r == {{(hcd_pkg::SIZE_BITS-1){1'b0}}, 1'b1}) begin
            phase_nxt = PH_CR;
          end
        end
        PH_CR: begin
          if (c == hcd_pkg::CH_CR) phase_nxt = PH_LF;
          else err_nxt = 1'b1;
        end
        PH_LF: begin
          if (c == hcd_pkg::CH_LF) begin
            phase_nxt   = PH_LINE;
            len_nxt     = '0;
            prev_cr_nxt = 1'b0;
            nphase_nxt  = NP_LEAD;
            neg_nxt     = 1'b0;
            accum_nxt   = '0;
          end else begin
            err_nxt = 1'b1;
          end
        end
        default: begin
          phase_nxt = phase_r;
        end
      endcase
    end

    ok = !err_nxt && ((phase_nxt == PH_DONE) || ((phase_nxt == PH_LINE) && (len_nxt == '0)));

    // The final byte gives only the status item and restarts the decoder.
    if (item.last) begin
      res.emit    = 1'b1;
      res.data    = 8'h00;
      res.is_end  = 1'b1;
      res.ok      = ok;
      phase_nxt   = PH_LINE;
      nphase_nxt  = NP_LEAD;
      remain_nxt  = '0;
      accum_nxt   = '0;
      len_nxt     = '0;
      prev_cr_nxt = 1'b0;
      neg_nxt     = 1'b0;
      err_nxt     = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_LINE;
      nphase_r  <= NP_LEAD;
      remain_r  <= '0;
      accum_r   <= '0;
      len_r     <= '0;
      prev_cr_r <= 1'b0;
      neg_r     <= 1'b0;
      err_r     <= 1'b0;
    end else if (step_en) begin
      phase_r   <= phase_nxt;
      nphase_r  <= nphase_nxt;
      remain_r  <= remain_nxt;
      accum_r   <= accum_nxt;
      len_r     <= len_nxt;
      prev_cr_r <= prev_cr_nxt;
      neg_r     <= neg_nxt;
      err_r     <= err_nxt;
    end
  end

endmodule

/* rtl/core/hcd_out_reg.sv */
// Result register of the chunked body decoder.
module hcd_out_reg (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               load,
  input  hcd_pkg::step_res_t res,
  output logic               free,
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [7:0]         out_tdata,
  output logic               out_tlast,
  output logic               out_tuser
);

  logic       valid_r, valid_nxt;
  logic [7:0] data_r;
  logic       last_r;
  logic       ok_r;

  // The slot can take a new item when empty or when its item leaves now.
  assign free = !valid_r || out_tready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_tready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= res.data;
      last_r <= res.is_end;
      ok_r   <= res.ok;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = data_r;
  assign out_tlast  = last_r;
  assign out_tuser  = ok_r;

endmodule

/* rtl/core/http_chunked_decoder.sv */
// Top level of the HTTP chunked body decoder.
//
// Usage: body bytes enter on the in_ stream, one byte per item, with in_tlast
// set on the final byte of each body. The decoder strips the chunk-size lines
// and the CR LF after each chunk and sends every payload byte out on the out_
// stream as a data item (out_tlast low). On the final byte of a body it sends
// one status item with out_tlast high and out_tuser giving the verdict: 1 the
// body was well formed, 0 it was malformed and the payload already sent must
// be discarded. Bytes after a zero-size chunk or after an error are absorbed
// without output until in_tlast.
// Path: an accepted item is held in the input register, processed by the framing
// parser and its result registered in the result register, which drives the out_
// stream. Throughput: one byte per cycle while no byte with output waits on a
// stalled out_ stream; the framing parser updates its state once per byte.
// Reset: rst_n is synchronous and active low; it empties both registers and
// returns the parser to the start of a size line. After each status item the
// parser also restarts, so the next byte opens a new body.
// Stalls: when out_tready is low the result register holds its item; the
// input register still takes one more byte and keeps flowing bytes that
// produce no output, and in_tready drops only when a byte with output waits.
module http_chunked_decoder (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] in_byte
  input  logic       in_tlast,   // in_last
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_data
  output logic       out_tlast,  // out_is_end
  output logic       out_tuser   // [0] out_ok
);

  hcd_pkg::in_item_t  in_item;
  hcd_pkg::in_item_t  hold_item;
  hcd_pkg::step_res_t res;
  logic               hold_valid;
  logic               out_free;
  logic               take;

  assign in_item.byte_val = in_tdata;
  assign in_item.last     = in_tlast;

  // A held byte moves on when its result, if any, has a free output slot.
  assign take = hold_valid && (out_free || !res.emit);

  hcd_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_item    (in_item),
    .take       (take),
    .hold_valid (hold_valid),
    .hold_item  (hold_item)
  );

  hcd_parse u_parse (
    .clk     (clk),
    .rst_n   (rst_n),
    .item    (hold_item),
    .step_en (take),
    .res     (res)
  );

  hcd_out_reg u_out_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (take && res.emit),
    .res        (res),
    .free       (out_free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule
